>>> hdl/mbt_pkg.sv
// Shared types and constants of the meter binding table.
`timescale 1ns / 1ps
`default_nettype none
package mbt_pkg;

  // Default table capacity and widths that cover the whole capacity range.
  localparam int CAPACITY_DEF = 64;
  localparam int POS_W        = 10;
  localparam int CNT_W        = 11;

  typedef logic [2:0] action_t;
  localparam action_t ACT_ADD  = 3'd0;
  localparam action_t ACT_LKI  = 3'd1;
  localparam action_t ACT_SET  = 3'd2;
  localparam action_t ACT_LKID = 3'd3;
  localparam action_t ACT_CLR  = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_NONE = 2'd1;
  localparam status_t ST_DUP  = 2'd2;
  localparam status_t ST_FULL = 2'd3;

  typedef struct packed {
    logic [7:0]  dtype;
    logic [31:0] mid;
    logic [15:0] manuf;
    logic [7:0]  ver;
  } ident_t;

  typedef struct packed {
    ident_t      ident;
    logic [14:0] idx;
    logic        flag;
  } entry_t;

  // Search token that walks down the row of cells.
  typedef struct packed {
    logic             vld;
    action_t          act;
    ident_t           ident;
    logic [14:0]      idx;
    logic             enc;
    logic             id_found;
    logic             idx_found;
    logic [POS_W-1:0] idx_pos;
    entry_t           hit;
  } tok_t;

  // Write broadcast from the controller to the cells.
  typedef struct packed {
    logic             we;
    logic             setf;
    logic [POS_W-1:0] pos;
    entry_t           ent;
  } wr_t;

endpackage
`default_nettype wire

>>> hdl/mbt_if.sv
// Request and response channel interfaces of the meter binding table.
`timescale 1ns / 1ps
`default_nettype none
interface mbt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [14:0] entry_idx;
  logic [7:0]  dev_type;
  logic [31:0] meter_id;
  logic [15:0] manufacturer;
  logic [7:0]  version;
  logic        encrypted;
  modport source (output valid, action, entry_idx, dev_type, meter_id, manufacturer,
                  version, encrypted, input ready);
  modport sink (input valid, action, entry_idx, dev_type, meter_id, manufacturer,
                version, encrypted, output ready);
endinterface

interface mbt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [14:0] found_index;
  logic [7:0]  type_out;
  logic [31:0] id_out;
  logic [15:0] manuf_out;
  logic [7:0]  version_out;
  logic        encrypted_out;
  logic [6:0]  entry_count;
  modport source (output valid, status, found_index, type_out, id_out, manuf_out,
                  version_out, encrypted_out, entry_count, input ready);
  modport sink (input valid, status, found_index, type_out, id_out, manuf_out,
                version_out, encrypted_out, entry_count, output ready);
endinterface
`default_nettype wire

>>> hdl/mbt_cell.sv
// One table entry with its stage of the search token chain.
`timescale 1ns / 1ps
`default_nettype none
module mbt_cell import mbt_pkg::*; #(
  parameter int P = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire tok_t             tok_i,
  input  wire wr_t              wr_i,
  output tok_t                  tok_o
);

  entry_t ent_q;
  tok_t   tok_d, pay_q;
  logic   vld_q;
  logic   en, m_id, m_ix;

  // The entry takes part only while it lies below the fill count.
  assign en   = CNT_W'(P) < count_i;
  assign m_id = en && (ent_q.ident == tok_i.ident);
  assign m_ix = en && (ent_q.idx == tok_i.idx);

  // Record the first identity and index match along the row.
  always_comb begin
    tok_d = tok_i;
    if (m_id && !tok_i.id_found) begin
      tok_d.id_found = 1'b1;
      if (tok_i.act == ACT_LKID) tok_d.hit = ent_q;
    end
    if (m_ix && !tok_i.idx_found) begin
      tok_d.idx_found = 1'b1;
      tok_d.idx_pos   = POS_W'(P);
      if (tok_i.act == ACT_LKI || tok_i.act == ACT_SET) tok_d.hit = ent_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= tok_d;
  end

  // Entry update from the controller's write broadcast.
  always_ff @(posedge clk_i) begin
    if (wr_i.we && wr_i.pos == POS_W'(P)) begin
      if (wr_i.setf) begin
        ent_q.flag <= 1'b1;
      end else begin
        ent_q <= wr_i.ent;
      end
    end
  end

  always_comb begin
    tok_o     = pay_q;
    tok_o.vld = vld_q;
  end

endmodule
`default_nettype wire

>>> hdl/meter_binding_table.sv
// Top level of the meter binding table: cell row and action controller.
// Flow: an accepted item's search token passes the CAPACITY cells one per
// cycle, and the result is registered once the token leaves the last cell.
// The block takes a new item only when idle, once the result of the last one
// is taken; the token walk along the cell row and the response wait hold it.
// Reset: the fill count clears at once; entry contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module meter_binding_table import mbt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mbt_req_if.sink   in_i,
  mbt_rsp_if.source out_o
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_RESP} state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q, cnt_n;
  tok_t             tok [0:CAPACITY];
  tok_t             last;
  wr_t              wr;
  status_t          st_n, st_q;
  entry_t           rep_n, rep_q;
  logic             rsp_vld_q, acc;

  assign acc        = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // Token injected at the head of the row.
  always_comb begin
    tok[0]             = '0;
    tok[0].vld         = acc;
    tok[0].act         = in_i.action;
    tok[0].ident.dtype = in_i.dev_type;
    tok[0].ident.mid   = in_i.meter_id;
    tok[0].ident.manuf = in_i.manufacturer;
    tok[0].ident.ver   = in_i.version;
    tok[0].idx         = in_i.entry_idx;
    tok[0].enc         = in_i.encrypted;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    mbt_cell #(.P(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count_q),
      .tok_i   (tok[g]),
      .wr_i    (wr),
      .tok_o   (tok[g+1])
    );
  end

  assign last = tok[CAPACITY];

  // Decide the action once the token leaves the last cell.
  always_comb begin
    st_n         = ST_NONE;
    rep_n        = '0;
    cnt_n        = count_q;
    wr           = '0;
    wr.ent.ident = last.ident;
    wr.ent.idx   = last.idx;
    wr.ent.flag  = last.enc;
    case (last.act)
      ACT_ADD: begin
        if (count_q >= CNT_W'(CAPACITY)) begin
          st_n = ST_FULL;
        end else if (last.id_found) begin
          st_n = ST_DUP;
        end else begin
          st_n  = ST_OK;
          wr.we = 1'b1;
          if (last.idx_found) begin
            wr.pos = last.idx_pos;
          end else begin
            wr.pos = POS_W'(count_q);
            cnt_n  = count_q + CNT_W'(1);
          end
        end
      end
      ACT_LKI: begin
        if (last.idx_found) begin
          st_n  = ST_OK;
          rep_n = last.hit;
        end
      end
      ACT_SET: begin
        if (last.idx_found) begin
          st_n       = ST_OK;
          rep_n      = last.hit;
          rep_n.flag = 1'b1;
          wr.we      = 1'b1;
          wr.setf    = 1'b1;
          wr.pos     = last.idx_pos;
        end
      end
      ACT_LKID: begin
        if (last.id_found) begin
          st_n  = ST_OK;
          rep_n = last.hit;
        end
      end
      ACT_CLR: begin
        st_n  = ST_OK;
        cnt_n = '0;
      end
      default: begin
        st_n = ST_NONE;
      end
    endcase
    if (!(state_q == S_WALK && last.vld)) wr.we = 1'b0;
  end

  // Controller state, fill count and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      st_q      <= ST_NONE;
      rep_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (acc) state_q <= S_WALK;
        end
        S_WALK: begin
          if (last.vld) begin
            st_q      <= st_n;
            rep_q     <= rep_n;
            count_q   <= cnt_n;
            rsp_vld_q <= 1'b1;
            state_q   <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_o.ready) begin
            rsp_vld_q <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid         = rsp_vld_q;
  assign out_o.status        = st_q;
  assign out_o.found_index   = rep_q.idx;
  assign out_o.type_out      = rep_q.ident.dtype;
  assign out_o.id_out        = rep_q.ident.mid;
  assign out_o.manuf_out     = rep_q.ident.manuf;
  assign out_o.version_out   = rep_q.ident.ver;
  assign out_o.encrypted_out = rep_q.flag;
  assign out_o.entry_count   = count_q[6:0];

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY)) else $error("fill count above capacity");

  // A token reaches the row end only while the controller waits for it.
  a_token_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.vld |-> state_q == S_WALK) else $error("stray search token");

  // An entry write is followed by a pending result.
  a_write_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |=> (state_q == S_RESP && rsp_vld_q)) else $error("write without result");

  // An accepted item starts a walk with no result shown.
  a_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (state_q == S_WALK && !rsp_vld_q)) else $error("accept did not start walk");

endmodule
`default_nettype wire

>>> bench/meter_binding_table_tb.sv
// Self-checking testbench of the meter binding table with a scoreboard class.
`timescale 1ns / 1ps
module meter_binding_table_tb;
  import mbt_pkg::*;

  localparam int DEPTH = 64;
  localparam int IDLE_LIMIT = 20000;

  // Action codes that the block does not define.
  localparam action_t ACT_RSVD_LO = 3'd5;
  localparam action_t ACT_RSVD_HI = 3'd7;

  // One expected or observed result item.
  typedef struct packed {
    status_t     status;
    logic [14:0] found_index;
    ident_t      ident;
    logic        flag;
    logic [6:0]  entry_count;
  } rsp_t;

  // One request item.
  typedef struct packed {
    action_t     action;
    logic [14:0] entry_idx;
    ident_t      ident;
    logic        encrypted;
  } req_t;

  int errors = 0;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Table predictor and queue of pending expected results.
  class binding_scoreboard;
    ident_t      idents[DEPTH];
    logic [14:0] idxs[DEPTH];
    logic        flags[DEPTH];
    int          fill;
    rsp_t        pending[$];

    function int find_index(input logic [14:0] idx);
      for (int e = 0; e < fill; e++) if (idxs[e] == idx) return e;
      return -1;
    endfunction

    function int find_ident(input ident_t id);
      for (int e = 0; e < fill; e++) if (idents[e] == id) return e;
      return -1;
    endfunction

    function void note_request(input req_t r);
      rsp_t x;
      int e;
      x = '0;
      x.status = ST_NONE;
      e = -1;
      case (r.action)
        ACT_ADD: begin
          if (fill >= DEPTH) x.status = ST_FULL;
          else if (find_ident(r.ident) >= 0) x.status = ST_DUP;
          else begin
            e = find_index(r.entry_idx);
            if (e < 0) begin
              e = fill;
              fill++;
            end
            idents[e] = r.ident;
            idxs[e] = r.entry_idx;
            flags[e] = r.encrypted;
            x.status = ST_OK;
            e = -1;
          end
        end
        ACT_LKI: e = find_index(r.entry_idx);
        ACT_SET: begin
          e = find_index(r.entry_idx);
          if (e >= 0) flags[e] = 1'b1;
        end
        ACT_LKID: e = find_ident(r.ident);
        ACT_CLR: begin
          fill = 0;
          x.status = ST_OK;
        end
        default: ;
      endcase
      if (e >= 0) begin
        x.status = ST_OK;
        x.found_index = idxs[e];
        x.ident = idents[e];
        x.flag = flags[e];
      end
      x.entry_count = fill[6:0];
      pending.push_back(x);
    endfunction

    task check_result(input rsp_t got);
      rsp_t w;
      if (pending.size() == 0) begin
        report("result with none expected");
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status)
        report($sformatf("status %0d, expected %0d", got.status, w.status));
      if (got.found_index !== w.found_index)
        report($sformatf("found_index %0h, expected %0h", got.found_index, w.found_index));
      if (got.ident !== w.ident)
        report($sformatf("identity %0h, expected %0h", got.ident, w.ident));
      if (got.flag !== w.flag)
        report($sformatf("encrypted_out %0b, expected %0b", got.flag, w.flag));
      if (got.entry_count !== w.entry_count)
        report($sformatf("entry_count %0d, expected %0d", got.entry_count, w.entry_count));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  mbt_req_if req_ch ();
  mbt_rsp_if rsp_ch ();

  meter_binding_table dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch.sink),
    .out_o (rsp_ch.source)
  );

  binding_scoreboard sb = new();
  bit quiet = 1'b0;
  int idle_cycles = 0;

  // A small pool of indexes and identities makes hits and duplicates common.
  logic [14:0] idx_pool[8];
  ident_t      id_pool[8];

  initial begin
    req_ch.valid = 1'b0;
    req_ch.action = ACT_ADD;
    req_ch.entry_idx = '0;
    req_ch.dev_type = '0;
    req_ch.meter_id = '0;
    req_ch.manufacturer = '0;
    req_ch.version = '0;
    req_ch.encrypted = 1'b0;
    rsp_ch.ready = 1'b0;
  end

  // Sample both channels at the rising edge.
  always @(posedge clk_i) begin
    rsp_t got;
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_request({req_ch.action, req_ch.entry_idx, req_ch.dev_type,
                         req_ch.meter_id, req_ch.manufacturer, req_ch.version,
                         req_ch.encrypted});
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = {rsp_ch.status, rsp_ch.found_index, rsp_ch.type_out, rsp_ch.id_out,
               rsp_ch.manuf_out, rsp_ch.version_out, rsp_ch.encrypted_out,
               rsp_ch.entry_count};
        sb.check_result(got);
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL meter_binding_table");
        $finish;
      end
    end
  end

  // Receiver stalls at random unless in a quiet stretch.
  always @(negedge clk_i)
    rsp_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 16);

  // Send one item and wait for its acceptance.
  task automatic send(input req_t r);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 16) @(negedge clk_i);
    req_ch.valid <= 1'b1;
    req_ch.action <= r.action;
    req_ch.entry_idx <= r.entry_idx;
    {req_ch.dev_type, req_ch.meter_id, req_ch.manufacturer, req_ch.version} <= r.ident;
    req_ch.encrypted <= r.encrypted;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
  endtask

  function automatic req_t make_req(input action_t a, input logic [14:0] idx,
                                    input ident_t id, input logic f);
    req_t r;
    r.action = a;
    r.entry_idx = idx;
    r.ident = id;
    r.encrypted = f;
    return r;
  endfunction

  function automatic ident_t rand_ident();
    return {$urandom(), $urandom()};
  endfunction

  // Random item biased toward the pools.
  function automatic req_t rand_req();
    int pick;
    action_t a;
    logic [14:0] idx;
    ident_t id;
    pick = $urandom_range(99);
    if (pick < 45) a = ACT_ADD;
    else if (pick < 62) a = ACT_LKI;
    else if (pick < 74) a = ACT_SET;
    else if (pick < 90) a = ACT_LKID;
    else if (pick < 93) a = ACT_CLR;
    else a = action_t'($urandom_range(7));
    idx = ($urandom_range(2) == 0) ? 15'($urandom()) : idx_pool[$urandom_range(7)];
    id = ($urandom_range(2) == 0) ? rand_ident() : id_pool[$urandom_range(7)];
    return make_req(a, idx, id, 1'($urandom_range(1)));
  endfunction

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);
  endtask

  initial begin
    ident_t ones;
    ones = '1;
    for (int i = 0; i < 8; i++) begin
      idx_pool[i] = 15'($urandom());
      id_pool[i] = rand_ident();
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, extremes, overwrite, duplicate, set, clear, bad actions.
    send(make_req(ACT_LKI, 15'h0, '0, 1'b0));
    send(make_req(ACT_LKID, 15'h0, '0, 1'b0));
    send(make_req(ACT_SET, 15'h7fff, '0, 1'b0));
    send(make_req(ACT_ADD, 15'h0, '0, 1'b0));
    send(make_req(ACT_ADD, 15'h7fff, ones, 1'b1));
    send(make_req(ACT_ADD, 15'h1234, ones, 1'b0));
    send(make_req(ACT_ADD, 15'h0, id_pool[0], 1'b1));
    send(make_req(ACT_LKI, 15'h0, '0, 1'b0));
    send(make_req(ACT_LKI, 15'h7fff, '0, 1'b0));
    send(make_req(ACT_LKID, 15'h0, ones, 1'b0));
    send(make_req(ACT_ADD, 15'h55, id_pool[1], 1'b0));
    send(make_req(ACT_SET, 15'h55, '0, 1'b0));
    send(make_req(ACT_LKID, 15'h0, id_pool[1], 1'b0));
    send(make_req(ACT_RSVD_LO, 15'h55, ones, 1'b1));
    send(make_req(ACT_RSVD_HI, 15'h0, '0, 1'b0));
    send(make_req(ACT_CLR, 15'h0, '0, 1'b0));
    send(make_req(ACT_LKI, 15'h55, '0, 1'b0));
    // Fill to capacity, then adds must be rejected as full.
    for (int i = 0; i < DEPTH; i++)
      send(make_req(ACT_ADD, 15'(i * 7), rand_ident(), i[0]));
    send(make_req(ACT_ADD, 15'h0, rand_ident(), 1'b0));
    send(make_req(ACT_ADD, 15'h7ff0, rand_ident(), 1'b0));
    send(make_req(ACT_LKI, 15'(63 * 7), '0, 1'b0));
    drain();

    // Random traffic, with a quiet stretch and one full drain midway.
    for (int n = 0; n < 1550; n++) begin
      quiet = (n >= 600 && n < 800);
      if (n == 1000) drain();
      send(rand_req());
    end
    quiet = 1'b0;
    drain();
    if (errors == 0)
      $display("PASS meter_binding_table");
    else
      $display("FAIL meter_binding_table");
    $finish;
  end
endmodule
